[hw/rtl/swcd_pkg.sv]
// Package for the stopwatch and countdown timer block.
// Holds the operation codes, time widths and timer constants; no dependencies.
`default_nettype none

package swcd_pkg;

  localparam int unsigned TIME_BITS    = 48;
  localparam int unsigned SEC_W        = 17;
  localparam int unsigned MAX_PRESET_S = 86400;
  localparam int unsigned MINUTE_S     = 60;
  localparam int unsigned MS_PER_S     = 1000;
  // seconds left saturate here when the time base runs backwards
  localparam int unsigned SEC_CAP      = MAX_PRESET_S + 59;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SW_TOGGLE = 3'd1,
    OP_LAP       = 3'd2,
    OP_SW_CLEAR  = 3'd3,
    OP_CD_TOGGLE = 3'd4,
    OP_ADD_MIN   = 3'd5,
    OP_CD_CLEAR  = 3'd6
  } op_t;

endpackage

`default_nettype wire

[hw/rtl/swcd_ceil_sec.sv]
// Countdown remaining time: milliseconds to rounded-up seconds, with expiry detect.
// Depends on swcd_pkg. Divide by 1000 is a reciprocal multiply on the capped range.
`default_nettype none

module swcd_ceil_sec import swcd_pkg::*; (
  input  logic [TIME_BITS-1:0] diff_ms,
  output logic [SEC_W-1:0]     secs,
  output logic                 expired
);

  localparam longint unsigned CAP_MS = longint'(SEC_CAP) * longint'(MS_PER_S);
  localparam int unsigned DIV_W   = $clog2(CAP_MS + MS_PER_S);
  // 2^10 > 1000 keeps the reciprocal error below one step over the DIV_W range
  localparam int unsigned RSH     = DIV_W + 10;
  localparam longint unsigned RECIP = ((64'd1 << RSH) + MS_PER_S - 1) / MS_PER_S;
  localparam int unsigned RECIP_W = RSH - 9;
  localparam int unsigned PROD_W  = DIV_W + RECIP_W;

  logic                 over_cap;
  logic [DIV_W-1:0]     round_ms;
  logic [PROD_W-1:0]    prod;

  assign over_cap = diff_ms > TIME_BITS'(CAP_MS);
  assign round_ms = diff_ms[DIV_W-1:0] + DIV_W'(MS_PER_S - 1);
  assign prod     = PROD_W'(round_ms) * PROD_W'(RECIP);
  // zero or negative (top bit set) distance to the end time means expired
  assign expired  = (diff_ms == '0) || diff_ms[TIME_BITS-1];

  always_comb begin
    if (expired) begin
      secs = '0;
    end else if (over_cap) begin
      secs = SEC_W'(SEC_CAP);
    end else begin
      secs = prod[RSH +: SEC_W];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/stopwatch_and_countdown_timer.sv]
// Stopwatch with lap and countdown timer, top level.
// Depends on swcd_pkg and swcd_ceil_sec.
`default_nettype none

// One operation and a millisecond timestamp go in per transfer; one result comes
// out per transfer, showing both the stopwatch and the countdown after the update.
// Each item passes through the input register and then the result register,
// and a new item is taken every cycle while the result side does not stall. The
// longest path is the countdown's remaining-time subtract followed by the
// reciprocal multiply that turns milliseconds into rounded-up seconds. All
// millisecond arithmetic wraps at 48 bits; code 7 changes nothing but still
// yields a result.
module stopwatch_and_countdown_timer import swcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_op,
  input  logic [TIME_BITS-1:0] in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TIME_BITS-1:0] out_stopwatch_ms,
  output logic [TIME_BITS-1:0] out_lap_value_ms,
  output logic                 out_stopwatch_running,
  output logic [SEC_W-1:0]     out_seconds_left,
  output logic                 out_timer_counting,
  output logic                 out_timer_rang,
  output logic                 out_expired_now
);

  // input register
  logic                 s1_valid_r;
  op_t                  op_r;
  logic [TIME_BITS-1:0] now_r;

  // block state
  logic                 sw_running_r, sw_running_nxt;
  logic [TIME_BITS-1:0] sw_start_r, sw_start_nxt;
  logic [TIME_BITS-1:0] sw_acc_r, sw_acc_nxt;
  logic [TIME_BITS-1:0] sw_lap_r, sw_lap_nxt;
  logic [SEC_W-1:0]     cd_preset_r, cd_preset_nxt;
  logic [TIME_BITS-1:0] cd_end_r, cd_end_nxt;
  logic                 cd_counting_r, cd_counting_nxt;
  logic                 cd_rang_r, cd_rang_nxt;

  // result register
  logic                 out_valid_r;
  logic [TIME_BITS-1:0] out_sw_ms_r, out_lap_r;
  logic                 out_sw_run_r;
  logic [SEC_W-1:0]     out_secs_r;
  logic                 out_counting_r, out_rang_r, out_expired_r;

  logic                 out_load, fire, expired_nxt;
  logic [TIME_BITS-1:0] sw_val_old, cd_diff;
  logic [SEC_W-1:0]     cd_secs, secs_out;
  logic                 cd_zero;

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign fire     = s1_valid_r && out_load;

  assign sw_val_old = sw_running_r ? (sw_acc_r + (now_r - sw_start_r)) : sw_acc_r;
  assign cd_diff    = cd_end_r - now_r;

  swcd_ceil_sec u_ceil (
    .diff_ms (cd_diff),
    .secs    (cd_secs),
    .expired (cd_zero)
  );

  always_comb begin
    sw_running_nxt  = sw_running_r;
    sw_start_nxt    = sw_start_r;
    sw_acc_nxt      = sw_acc_r;
    sw_lap_nxt      = sw_lap_r;
    cd_preset_nxt   = cd_preset_r;
    cd_end_nxt      = cd_end_r;
    cd_counting_nxt = cd_counting_r;
    cd_rang_nxt     = cd_rang_r;
    expired_nxt     = 1'b0;
    case (op_r)
      OP_TICK: begin
        if (cd_counting_r && cd_zero) begin
          cd_counting_nxt = 1'b0;
          cd_rang_nxt     = 1'b1;
          cd_preset_nxt   = '0;
          expired_nxt     = 1'b1;
        end
      end
      OP_SW_TOGGLE: begin
        if (sw_running_r) begin
          sw_acc_nxt     = sw_val_old;
          sw_running_nxt = 1'b0;
        end else begin
          sw_start_nxt   = now_r;
          sw_running_nxt = 1'b1;
        end
      end
      OP_LAP: begin
        if (sw_running_r) sw_lap_nxt = sw_val_old;
      end
      OP_SW_CLEAR: begin
        if (!sw_running_r) begin
          sw_acc_nxt = '0;
          sw_lap_nxt = '0;
        end
      end
      OP_CD_TOGGLE: begin
        if (cd_counting_r) begin
          cd_preset_nxt   = cd_secs;
          cd_counting_nxt = 1'b0;
        end else if (cd_preset_r != '0) begin
          cd_end_nxt      = now_r + TIME_BITS'(cd_preset_r) * TIME_BITS'(MS_PER_S);
          cd_counting_nxt = 1'b1;
          cd_rang_nxt     = 1'b0;
        end
      end
      OP_ADD_MIN: begin
        if (!cd_counting_r && (cd_preset_r < SEC_W'(MAX_PRESET_S)))
          cd_preset_nxt = cd_preset_r + SEC_W'(MINUTE_S);
      end
      OP_CD_CLEAR: begin
        cd_counting_nxt = 1'b0;
        cd_rang_nxt     = 1'b0;
        cd_preset_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  // a fresh start reads exactly its preset; a continuing count reads the divider
  always_comb begin
    if (!cd_counting_nxt) begin
      secs_out = cd_preset_nxt;
    end else if (cd_counting_r) begin
      secs_out = cd_secs;
    end else begin
      secs_out = cd_preset_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r  <= op_t'(in_op);
      now_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_running_r  <= 1'b0;
      sw_start_r    <= '0;
      sw_acc_r      <= '0;
      sw_lap_r      <= '0;
      cd_preset_r   <= '0;
      cd_end_r      <= '0;
      cd_counting_r <= 1'b0;
      cd_rang_r     <= 1'b0;
    end else if (fire) begin
      sw_running_r  <= sw_running_nxt;
      sw_start_r    <= sw_start_nxt;
      sw_acc_r      <= sw_acc_nxt;
      sw_lap_r      <= sw_lap_nxt;
      cd_preset_r   <= cd_preset_nxt;
      cd_end_r      <= cd_end_nxt;
      cd_counting_r <= cd_counting_nxt;
      cd_rang_r     <= cd_rang_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_sw_ms_r    <= sw_running_nxt ? sw_val_old : sw_acc_nxt;
      out_lap_r      <= sw_lap_nxt;
      out_sw_run_r   <= sw_running_nxt;
      out_secs_r     <= secs_out;
      out_counting_r <= cd_counting_nxt;
      out_rang_r     <= cd_rang_nxt;
      out_expired_r  <= expired_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_stopwatch_ms      = out_sw_ms_r;
  assign out_lap_value_ms      = out_lap_r;
  assign out_stopwatch_running = out_sw_run_r;
  assign out_seconds_left      = out_secs_r;
  assign out_timer_counting    = out_counting_r;
  assign out_timer_rang        = out_rang_r;
  assign out_expired_now       = out_expired_r;

`ifndef SYNTH
  // rang is only set on expiry and cleared by a restart or a clear
  a_rang_not_counting: assert property (@(posedge clk) disable iff (!rst_n)
    cd_rang_r |-> !cd_counting_r)
    else $error("timer rang while still counting");

  a_rang_from_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cd_rang_r) |-> $past(cd_counting_r) && $past(op_r) == OP_TICK)
    else $error("rang set without a running countdown expiring");

  a_expired_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_expired_r |-> out_rang_r && !out_counting_r && out_secs_r == '0)
    else $error("expiry result inconsistent with timer state");
`endif

endmodule

`default_nettype wire

[bench/swcd_checker.sv]
// Checker for the stopwatch and countdown timer: watches both channels,
// predicts each result from accepted transfers and compares field by field.
// Depends on swcd_pkg for widths, timer constants and operation codes.
`timescale 1ns / 100ps

module swcd_checker import swcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           in_op,
  input  logic [TIME_BITS-1:0] in_now_ms,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [TIME_BITS-1:0] out_stopwatch_ms,
  input  logic [TIME_BITS-1:0] out_lap_value_ms,
  input  logic                 out_stopwatch_running,
  input  logic [SEC_W-1:0]     out_seconds_left,
  input  logic                 out_timer_counting,
  input  logic                 out_timer_rang,
  input  logic                 out_expired_now,
  output int                   fail_count,
  output int                   pending
);

  typedef struct {
    logic [TIME_BITS-1:0] sw_ms;
    logic [TIME_BITS-1:0] lap_ms;
    logic                 sw_run;
    logic [SEC_W-1:0]     secs;
    logic                 cd_run;
    logic                 rang;
    logic                 fired;
  } reading_t;

  // predicted timer state
  logic                 sw_run;
  logic [TIME_BITS-1:0] sw_t0;
  logic [TIME_BITS-1:0] sw_acc;
  logic [TIME_BITS-1:0] sw_lap;
  logic [SEC_W-1:0]     cd_preset;
  logic [TIME_BITS-1:0] cd_end;
  logic                 cd_run;
  logic                 cd_rang;

  reading_t due_readings[$];
  reading_t want;

  function automatic logic [TIME_BITS-1:0] sw_reading(input logic [TIME_BITS-1:0] now);
    if (!sw_run) return sw_acc;
    return sw_acc + (now - sw_t0);
  endfunction

  function automatic logic [SEC_W-1:0] secs_remaining(input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] secs;
    if (!cd_run) return cd_preset;
    diff = cd_end - now;
    // zero or a negative distance (top bit set) means the deadline has passed
    if (diff == '0 || diff[TIME_BITS-1]) return '0;
    secs = diff / MS_PER_S + ((diff % MS_PER_S != 0) ? 1 : 0);
    if (secs > SEC_CAP) secs = TIME_BITS'(SEC_CAP);
    return secs[SEC_W-1:0];
  endfunction

  function automatic reading_t advance_timers(input logic [2:0] op,
                                              input logic [TIME_BITS-1:0] now);
    reading_t r;
    logic     fired;
    fired = 1'b0;
    case (op)
      OP_TICK: begin
        if (cd_run && secs_remaining(now) == '0) begin
          cd_run    = 1'b0;
          cd_rang   = 1'b1;
          cd_preset = '0;
          fired     = 1'b1;
        end
      end
      OP_SW_TOGGLE: begin
        if (sw_run) begin
          sw_acc = sw_reading(now);
          sw_run = 1'b0;
        end else begin
          sw_t0  = now;
          sw_run = 1'b1;
        end
      end
      OP_LAP: begin
        if (sw_run) sw_lap = sw_reading(now);
      end
      OP_SW_CLEAR: begin
        if (!sw_run) begin
          sw_acc = '0;
          sw_lap = '0;
        end
      end
      OP_CD_TOGGLE: begin
        if (cd_run) begin
          cd_preset = secs_remaining(now);
          cd_run    = 1'b0;
        end else if (cd_preset != '0) begin
          cd_end  = now + TIME_BITS'(cd_preset) * TIME_BITS'(MS_PER_S);
          cd_run  = 1'b1;
          cd_rang = 1'b0;
        end
      end
      OP_ADD_MIN: begin
        if (!cd_run && cd_preset < MAX_PRESET_S) cd_preset = cd_preset + SEC_W'(MINUTE_S);
      end
      OP_CD_CLEAR: begin
        cd_run    = 1'b0;
        cd_rang   = 1'b0;
        cd_preset = '0;
      end
      default: ;
    endcase
    r.sw_ms  = sw_reading(now);
    r.lap_ms = sw_lap;
    r.sw_run = sw_run;
    r.secs   = secs_remaining(now);
    r.cd_run = cd_run;
    r.rang   = cd_rang;
    r.fired  = fired;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp_val);
    fail_count++;
    $display("swcd_checker %0t: %s got %0h want %0h", $time, what, got, exp_val);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) flag_mismatch(what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sw_run     = 1'b0;
      sw_t0      = '0;
      sw_acc     = '0;
      sw_lap     = '0;
      cd_preset  = '0;
      cd_end     = '0;
      cd_run     = 1'b0;
      cd_rang    = 1'b0;
      fail_count = 0;
      due_readings.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) due_readings.push_back(advance_timers(in_op, in_now_ms));
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          flag_mismatch("result transfer with nothing pending", '0, '0);
        end else begin
          want = due_readings.pop_front();
          check_field("stopwatch_ms", out_stopwatch_ms, want.sw_ms);
          check_field("lap_value_ms", out_lap_value_ms, want.lap_ms);
          check_field("stopwatch_running", out_stopwatch_running, want.sw_run);
          check_field("seconds_left", out_seconds_left, want.secs);
          check_field("timer_counting", out_timer_counting, want.cd_run);
          check_field("timer_rang", out_timer_rang, want.rang);
          check_field("expired_now", out_expired_now, want.fired);
        end
      end
      pending <= due_readings.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Top of the stopwatch and countdown timer testbench: clock, reset, stimulus,
// result-side stalls, watchdog and verdict. Depends on swcd_pkg,
// stopwatch_and_countdown_timer and swcd_checker.
`timescale 1ns / 100ps

module tb_top import swcd_pkg::*; ();

  localparam logic [2:0] OP_UNUSED    = 3'd7;
  localparam int         RANDOM_ITEMS = 1700;
  localparam int         QUIET_TAIL   = 200;
  localparam int         STUCK_LIMIT  = 1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_op = OP_TICK;
  logic [TIME_BITS-1:0] in_now_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TIME_BITS-1:0] out_stopwatch_ms;
  logic [TIME_BITS-1:0] out_lap_value_ms;
  logic                 out_stopwatch_running;
  logic [SEC_W-1:0]     out_seconds_left;
  logic                 out_timer_counting;
  logic                 out_timer_rang;
  logic                 out_expired_now;

  int fail_count;
  int pending;
  int sent = 0;
  int stall_left = 0;
  int stuck_cycles = 0;
  bit noisy = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stopwatch_and_countdown_timer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_stopwatch_ms      (out_stopwatch_ms),
    .out_lap_value_ms      (out_lap_value_ms),
    .out_stopwatch_running (out_stopwatch_running),
    .out_seconds_left      (out_seconds_left),
    .out_timer_counting    (out_timer_counting),
    .out_timer_rang        (out_timer_rang),
    .out_expired_now       (out_expired_now)
  );

  swcd_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_stopwatch_ms      (out_stopwatch_ms),
    .out_lap_value_ms      (out_lap_value_ms),
    .out_stopwatch_running (out_stopwatch_running),
    .out_seconds_left      (out_seconds_left),
    .out_timer_counting    (out_timer_counting),
    .out_timer_rang        (out_timer_rang),
    .out_expired_now       (out_expired_now),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  // result-side stalls in random bursts while noisy
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (noisy && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one input transfer, then maybe a random gap
  task automatic send(input logic [2:0] op, input logic [TIME_BITS-1:0] now);
    in_op     <= op;
    in_now_ms <= now;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (noisy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [TIME_BITS-1:0] t_ms;
    logic [TIME_BITS-1:0] deadline;
    logic [63:0]          rnd;
    int                   mins;
    int                   target;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, unused code, ignored ops, wrap of the time base
    send(OP_TICK, '0);
    send(OP_UNUSED, '1);
    send(OP_LAP, 48'd5);
    send(OP_CD_TOGGLE, 48'd10);
    send(OP_SW_TOGGLE, 48'hFFFF_FFFF_FF00);
    send(OP_LAP, 48'h100);
    send(OP_SW_CLEAR, 48'h180);
    send(OP_SW_TOGGLE, 48'h500);
    send(OP_SW_CLEAR, 48'h600);
    send(OP_ADD_MIN, 48'h700);
    send(OP_ADD_MIN, 48'h800);
    // deadline wraps past zero to 54464
    send(OP_CD_TOGGLE, 48'hFFFF_FFFF_0000);
    send(OP_ADD_MIN, 48'hFFFF_FFFF_8000);
    send(OP_TICK, 48'd54463);
    send(OP_TICK, 48'd54464);
    send(OP_TICK, 48'd54465);
    // halt with time far behind the deadline saturates the seconds left
    send(OP_ADD_MIN, 48'd60000);
    send(OP_CD_TOGGLE, 48'd70000);
    send(OP_CD_TOGGLE, 48'd130000 - 48'h0100_0000_0000);
    send(OP_ADD_MIN, 48'd200000);
    send(OP_CD_TOGGLE, 48'd300000);
    send(OP_TICK, 48'd300000 + 48'd86459000 + 48'd5);
    send(OP_SW_TOGGLE, '0);
    send(OP_SW_TOGGLE, '1);
    send(OP_CD_CLEAR, '0);
    drain_results();

    t_ms   = 48'd1000;
    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      if (sent >= target - QUIET_TAIL) noisy = 1'b0;
      else if ($urandom_range(0, 7) == 0) noisy = !noisy;
      if (noisy && $urandom_range(0, 29) == 0) drain_results();

      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          // countdown: preset a few minutes, start, tick toward the deadline
          mins = $urandom_range(1, 3);
          if ($urandom_range(0, 3) != 0) send(OP_CD_CLEAR, t_ms);
          repeat (mins) begin
            t_ms = t_ms + $urandom_range(0, 500);
            send(OP_ADD_MIN, t_ms);
          end
          send(OP_CD_TOGGLE, t_ms);
          deadline = t_ms + TIME_BITS'(mins) * 48'd60000;
          repeat ($urandom_range(3, 15)) begin
            case ($urandom_range(0, 9))
              0:       t_ms = deadline;
              1:       t_ms = deadline - 48'd1;
              2:       t_ms = deadline + 48'd1;
              default: t_ms = t_ms + $urandom_range(1, 20000);
            endcase
            case ($urandom_range(0, 7))
              0:       send(OP_CD_TOGGLE, t_ms);
              1:       send(OP_ADD_MIN, t_ms);
              2:       send(3'($urandom_range(int'(OP_SW_TOGGLE), int'(OP_SW_CLEAR))), t_ms);
              default: send(OP_TICK, t_ms);
            endcase
          end
        end
        9, 10, 11, 12, 13, 14: begin
          // stopwatch: start/halt, laps, clears, with occasional long runs
          repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 9) == 0) t_ms = t_ms + $urandom;
            else t_ms = t_ms + $urandom_range(0, 5000);
            case ($urandom_range(0, 4))
              0, 1:    send(OP_SW_TOGGLE, t_ms);
              2:       send(OP_LAP, t_ms);
              3:       send(OP_SW_CLEAR, t_ms);
              default: send(OP_TICK, t_ms);
            endcase
          end
        end
        15, 16, 17: begin
          // any code, any time
          repeat ($urandom_range(1, 5)) begin
            rnd = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0) send(3'($urandom_range(0, 7)), rnd[TIME_BITS-1:0]);
            else send(3'($urandom_range(0, 7)), t_ms);
          end
        end
        default: begin
          // time base jumps backward, to the edge of wrap, or far ahead
          case ($urandom_range(0, 2))
            0:       t_ms = t_ms - $urandom_range(1, 100000000);
            1:       t_ms = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 200000);
            default: t_ms = t_ms + {16'($urandom_range(0, 65535)), $urandom};
          endcase
          send(3'($urandom_range(0, 7)), t_ms);
        end
      endcase
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[stopwatch_and_countdown_timer.f]
hw/rtl/swcd_pkg.sv
hw/rtl/swcd_ceil_sec.sv
hw/rtl/stopwatch_and_countdown_timer.sv
bench/swcd_checker.sv
bench/tb_top.sv
